// ----- rtl/core/gcr62_pkg.sv -----
`timescale 1ns / 1ps

package gcr62_pkg;

  localparam int unsigned AuxCount  = 86;
  localparam int unsigned AuxAddrW  = 7;
  localparam logic [8:0]  AuxEnd    = 9'd86;
  localparam logic [8:0]  DataEnd   = 9'd342;
  localparam logic [8:0]  DonePos   = 9'd343;
  localparam logic [7:0]  Sec1Start = 8'd86;
  localparam logic [7:0]  Sec2Start = 8'd172;

  typedef enum logic [1:0] {
    SEC_LOW  = 2'd0,
    SEC_MID  = 2'd1,
    SEC_HIGH = 2'd2
  } sec_e;

  // item waiting on the aux RAM read
  typedef struct packed {
    logic [5:0] chain;
    sec_e       sec;
    logic [7:0] index;
    logic       bad;
    logic       status;
    logic       ok;
  } s1_item_t;

  typedef struct packed {
    logic                en;
    logic                we;
    logic [AuxAddrW-1:0] addr;
    logic [5:0]          wdata;
  } ram_req_t;

  typedef struct packed {
    logic       bad;
    logic [5:0] value;
  } nib_dec_t;

  localparam logic [7:0] WriteTable [64] = '{
    8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
    8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
    8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
    8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
    8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
    8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
    8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
    8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

  // 6-and-2 read table: index of the matching entry, zero and bad on a miss
  function automatic nib_dec_t decode_nibble(input logic [7:0] nib);
    nib_dec_t res;
    res.bad   = 1'b1;
    res.value = 6'd0;
    for (int k = 0; k < 64; k++) begin
      if (WriteTable[6'(k)] == nib) begin
        res.bad   = 1'b0;
        res.value = 6'(k);
      end
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/gcr_6and2_sector_decoder.sv -----
`timescale 1ns / 1ps

// 6-and-2 data field decoder: one nibble per cycle, back to back while in_stall_o is low.
// After its nibble is accepted, a result beat passes the aux RAM read
// stage and then the output register.
// Throughput: 1 nibble per cycle while in_stall_o is low; the output register and
// the RAM read stage let input continue while one result beat waits on out_stall_i.
// Reset clears position, chain, error flag and valid bits; the aux RAM
// is not cleared, each field writes its entries before reading them.
module gcr_6and2_sector_decoder
  import gcr62_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] disk_nibble_i,
  input  logic       field_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic [7:0] byte_index_o,
  output logic       is_status_o,
  output logic       checksum_ok_o,
  output logic       bad_nibble_seen_o,
  output logic       last_o
);

  logic       accept;
  logic       issue;
  s1_item_t   item;
  ram_req_t   ram_req;
  logic [5:0] aux_rdata;

  logic       s1_valid_q;
  s1_item_t   s1_q;
  logic       s1_adv;
  logic       s1_load;
  logic [1:0] lo;

  logic       out_valid_q;
  logic [7:0] data_byte_q, data_byte_d;
  logic [7:0] byte_index_q;
  logic       is_status_q;
  logic       checksum_ok_q;
  logic       bad_q;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign s1_load    = !in_stall_o;
  assign accept     = in_valid_i && !in_stall_o;

  gcr62_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .disk_nibble_i (disk_nibble_i),
    .field_start_i (field_start_i),
    .issue_o       (issue),
    .item_o        (item),
    .ram_req_o     (ram_req)
  );

  gcr62_ram #(
    .Width (6),
    .Depth (AuxCount)
  ) u_aux_ram (
    .clk_i   (clk_i),
    .en_i    (ram_req.en),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (aux_rdata)
  );

  // swapped bit pair of the section the byte falls in
  always_comb begin
    case (s1_q.sec)
      SEC_LOW:  lo = {aux_rdata[0], aux_rdata[1]};
      SEC_MID:  lo = {aux_rdata[2], aux_rdata[3]};
      SEC_HIGH: lo = {aux_rdata[4], aux_rdata[5]};
      default:  lo = 2'b00;
    endcase
    data_byte_d = s1_q.status ? 8'd0 : {s1_q.chain, lo};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= issue;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && issue) begin
      s1_q <= item;
    end
    if (s1_adv && s1_valid_q) begin
      data_byte_q   <= data_byte_d;
      byte_index_q  <= s1_q.status ? 8'd0 : s1_q.index;
      is_status_q   <= s1_q.status;
      checksum_ok_q <= s1_q.ok;
      bad_q         <= s1_q.bad;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign data_byte_o       = data_byte_q;
  assign byte_index_o      = byte_index_q;
  assign is_status_o       = is_status_q;
  assign checksum_ok_o     = checksum_ok_q;
  assign bad_nibble_seen_o = bad_q;
  assign last_o            = is_status_q;

`ifndef SYNTHESIS
  a_status_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_status_o |-> data_byte_o == 8'd0 && byte_index_o == 8'd0)
    else $error("status beat carries byte data");

  a_data_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_status_o |-> !checksum_ok_o && !last_o)
    else $error("data beat carries status bits");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free pipeline");

  a_rdata_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> $stable(aux_rdata))
    else $error("aux read data changed under a held item");
`endif

endmodule

// ----- rtl/core/gcr62_ram.sv -----
`timescale 1ns / 1ps

module gcr62_ram #(
  parameter int unsigned Width = 6,
  parameter int unsigned Depth = 86
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read data only moves on a read, so it holds while the consumer waits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/gcr62_front.sv -----
`timescale 1ns / 1ps

module gcr62_front
  import gcr62_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] disk_nibble_i,
  input  logic       field_start_i,
  output logic       issue_o,
  output s1_item_t   item_o,
  output ram_req_t   ram_req_o
);

  logic [8:0] pos_q, pos_d;
  logic [5:0] chain_q, chain_d;
  logic       bad_q, bad_d;

  logic [8:0] pos_eff;
  logic [5:0] chain_eff;
  logic       bad_eff;
  logic [5:0] chain_new;
  logic       bad_new;
  logic [8:0] j_full;
  logic [7:0] j;
  logic       active;
  nib_dec_t   dec;

  always_comb begin
    pos_eff   = field_start_i ? 9'd0 : pos_q;
    chain_eff = field_start_i ? 6'd0 : chain_q;
    bad_eff   = field_start_i ? 1'b0 : bad_q;
    dec       = decode_nibble(disk_nibble_i);
    bad_new   = bad_eff | dec.bad;
    chain_new = dec.value ^ chain_eff;
    j_full    = pos_eff - AuxEnd;
    j         = j_full[7:0];
    active    = accept_i && (pos_eff < DonePos);

    pos_d   = pos_q;
    chain_d = chain_q;
    bad_d   = bad_q;
    issue_o = 1'b0;

    item_o.chain  = chain_new;
    item_o.sec    = SEC_LOW;
    item_o.index  = j;
    item_o.bad    = bad_new;
    item_o.status = 1'b0;
    item_o.ok     = 1'b0;

    ram_req_o.en    = 1'b0;
    ram_req_o.we    = 1'b0;
    ram_req_o.addr  = pos_eff[AuxAddrW-1:0];
    ram_req_o.wdata = chain_new;

    if (active) begin
      bad_d = bad_new;
      if (pos_eff == DataEnd) begin
        // checksum nibble: chain is compared, not advanced
        issue_o       = 1'b1;
        item_o.status = 1'b1;
        item_o.ok     = (dec.value == chain_eff);
        pos_d         = DonePos;
        chain_d       = chain_eff;
      end else begin
        chain_d = chain_new;
        pos_d   = pos_eff + 9'd1;
        ram_req_o.en = 1'b1;
        if (pos_eff < AuxEnd) begin
          ram_req_o.we = 1'b1;
        end else begin
          issue_o = 1'b1;
          if (j < Sec1Start) begin
            item_o.sec     = SEC_LOW;
            ram_req_o.addr = j[AuxAddrW-1:0];
          end else if (j < Sec2Start) begin
            item_o.sec     = SEC_MID;
            ram_req_o.addr = AuxAddrW'(j - Sec1Start);
          end else begin
            item_o.sec     = SEC_HIGH;
            ram_req_o.addr = AuxAddrW'(j - Sec2Start);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 9'd0;
      chain_q <= 6'd0;
      bad_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      chain_q <= chain_d;
      bad_q   <= bad_d;
    end
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] index;
    logic       status;
    logic       ok;
    logic       bad;
    logic       last;
  } sector_beat_t;

  // directed row: nibble, field start flag, beats it must produce
  typedef struct packed {
    logic [7:0] nib;
    logic       start;
    logic [1:0] beats;
  } nib_row_t;

  localparam int unsigned PairCount = 86;
  localparam int unsigned SumPos    = 342;
  localparam int unsigned DonePos   = 343;
  localparam int unsigned FieldLen  = 343;
  localparam int unsigned RandItems = 550;
  localparam int unsigned IdlePct   = 33;

  // 6-and-2 disk code: entry k is the nibble written for value k
  localparam logic [7:0] GcrNibbles [64] = '{
    8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
    8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
    8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
    8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
    8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
    8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
    8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
    8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] disk_nibble_i;
  logic       field_start_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] data_byte_o;
  logic [7:0] byte_index_o;
  logic       is_status_o;
  logic       checksum_ok_o;
  logic       bad_nibble_seen_o;
  logic       last_o;

  gcr_6and2_sector_decoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .disk_nibble_i    (disk_nibble_i),
    .field_start_i    (field_start_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .data_byte_o      (data_byte_o),
    .byte_index_o     (byte_index_o),
    .is_status_o      (is_status_o),
    .checksum_ok_o    (checksum_ok_o),
    .bad_nibble_seen_o(bad_nibble_seen_o),
    .last_o           (last_o)
  );

  // decoder state as seen by the checker
  logic [5:0]   pair_store [PairCount];
  int unsigned  field_pos = 0;
  logic [5:0]   chain     = 6'd0;
  logic         miss_seen = 1'b0;
  sector_beat_t sector_beats [$];

  bit          no_gaps   = 1'b0;
  int unsigned err_cnt   = 0;
  int unsigned bytes_cnt = 0;
  int unsigned sums_good = 0;
  int unsigned sums_bad  = 0;
  int unsigned nib_cnt   = 0;

  nib_row_t directed_rows [20] = '{
    '{8'h96, 1'b0, 2'd0},  // no field start after reset, lowest code
    '{8'hFF, 1'b0, 2'd0},  // highest code
    '{8'h00, 1'b0, 2'd0},  // not in table
    '{8'h95, 1'b0, 2'd0},
    '{8'hAA, 1'b0, 2'd0},
    '{8'hD5, 1'b0, 2'd0},
    '{8'h96, 1'b1, 2'd0},  // restart clears the miss flag
    '{8'hFF, 1'b1, 2'd0},
    '{8'h00, 1'b1, 2'd0},  // restart on a bad nibble
    '{8'hFF, 1'b0, 2'd0},
    '{8'h01, 1'b0, 2'd0},
    '{8'h80, 1'b0, 2'd0},
    '{8'h7F, 1'b0, 2'd0},
    '{8'hFE, 1'b0, 2'd0},
    '{8'hB2, 1'b0, 2'd0},
    '{8'hCB, 1'b0, 2'd0},
    '{8'hD3, 1'b0, 2'd0},
    '{8'hE5, 1'b0, 2'd0},
    '{8'hF2, 1'b0, 2'd0},
    '{8'hDE, 1'b0, 2'd0}
  };

  function automatic logic [5:0] gcr_lookup(input logic [7:0] nib, output logic miss);
    logic [5:0] val;
    val  = 6'd0;
    miss = 1'b1;
    for (int k = 0; k < 64; k++) begin
      if (GcrNibbles[6'(k)] == nib) begin
        val  = 6'(k);
        miss = 1'b0;
      end
    end
    return val;
  endfunction

  function automatic logic [7:0] random_miss();
    logic [7:0] nib;
    logic       miss;
    do begin
      nib = 8'($urandom_range(0, 255));
      void'(gcr_lookup(nib, miss));
    end while (!miss);
    return nib;
  endfunction

  // advances the decoder state by one nibble, queues the beat it yields
  task automatic gcr_decode(input logic [7:0] nib, input logic start, output int produced);
    sector_beat_t beat;
    logic [5:0]   val;
    logic [5:0]   pair;
    logic [1:0]   lo;
    logic         miss;
    int unsigned  j;
    produced = 0;
    if (start) begin
      field_pos = 0;
      chain     = 6'd0;
      miss_seen = 1'b0;
    end
    if (field_pos >= DonePos) return;
    val = gcr_lookup(nib, miss);
    if (miss) miss_seen = 1'b1;
    if (field_pos == SumPos) begin
      beat = '{8'd0, 8'd0, 1'b1, val == chain, miss_seen, 1'b1};
      sector_beats.push_back(beat);
      field_pos = DonePos;
      produced  = 1;
      return;
    end
    chain = chain ^ val;
    if (field_pos < PairCount) begin
      pair_store[7'(field_pos)] = chain;
      field_pos++;
      return;
    end
    j = field_pos - PairCount;
    // the two aux bits come out swapped
    if (j < PairCount) begin
      pair = pair_store[7'(j)];
      lo   = {pair[0], pair[1]};
    end else if (j < 2 * PairCount) begin
      pair = pair_store[7'(j - PairCount)];
      lo   = {pair[2], pair[3]};
    end else begin
      pair = pair_store[7'(j - 2 * PairCount)];
      lo   = {pair[4], pair[5]};
    end
    beat = '{{chain, lo}, 8'(j), 1'b0, 1'b0, miss_seen, 1'b0};
    sector_beats.push_back(beat);
    field_pos++;
    produced = 1;
  endtask

  task automatic send_nibble(input logic [7:0] nib, input logic start, output int produced);
    if (!no_gaps && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < IdlePct);
    end
    in_valid_i    <= 1'b1;
    disk_nibble_i <= nib;
    field_start_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    nib_cnt++;
    gcr_decode(nib, start, produced);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("gcr_6and2_sector_decoder: mismatch");
    $finish;
  end

  // result side: check each accepted beat, then pick the next stall
  initial begin
    sector_beat_t want;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (sector_beats.size() == 0) begin
          $error("unexpected beat: data_byte %0d byte_index %0d is_status %0d",
                 data_byte_o, byte_index_o, is_status_o);
          err_cnt++;
        end else begin
          want = sector_beats.pop_front();
          check_field("data_byte", 32'(want.data), 32'(data_byte_o));
          check_field("byte_index", 32'(want.index), 32'(byte_index_o));
          check_field("is_status", 32'(want.status), 32'(is_status_o));
          check_field("checksum_ok", 32'(want.ok), 32'(checksum_ok_o));
          check_field("bad_nibble_seen", 32'(want.bad), 32'(bad_nibble_seen_o));
          check_field("last", 32'(want.last), 32'(last_o));
          if (!want.status) bytes_cnt++;
          else if (want.ok) sums_good++;
          else sums_bad++;
        end
      end
      out_stall_i <= !no_gaps && ($urandom_range(0, 99) < IdlePct);
    end
  end

  initial begin
    int unsigned rand_items;
    int unsigned fields;
    int unsigned full_fields;
    int unsigned len;
    int          produced;
    logic [7:0]  nib;
    logic        full;
    logic        clean;
    logic        good;
    rand_items    = 0;
    fields        = 0;
    full_fields   = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    disk_nibble_i = 8'd0;
    field_start_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      send_nibble(directed_rows[r].nib, directed_rows[r].start, produced);
      if (produced != int'(directed_rows[r].beats)) begin
        $error("row %0d: beat count expected %0d, got %0d",
               r, directed_rows[r].beats, produced);
        err_cnt++;
      end
    end

    // whole fields with random content; some cut short by the next field start
    while (rand_items < RandItems || full_fields < 2) begin
      full  = (fields == 0) || ($urandom_range(0, 99) < 70);
      clean = 1'($urandom_range(0, 1));
      good  = (full_fields % 2 == 0);
      len   = full ? FieldLen : $urandom_range(1, FieldLen - 1);
      for (int unsigned i = 0; i < len; i++) begin
        if (i == SumPos)
          nib = good ? GcrNibbles[chain] : GcrNibbles[chain ^ 6'($urandom_range(1, 63))];
        else if (!clean && $urandom_range(0, 99) < 2)
          nib = random_miss();
        else
          nib = GcrNibbles[6'($urandom_range(0, 63))];
        no_gaps = (rand_items >= 150 && rand_items < 330);
        send_nibble(nib, i == 0, produced);
        rand_items++;
      end
      fields++;
      if (full) begin
        full_fields++;
        // trailing nibbles after the checksum are dropped
        repeat ($urandom_range(0, 4)) send_nibble(8'($urandom_range(0, 255)), 1'b0, produced);
      end
    end
    no_gaps = 1'b0;
    in_valid_i <= 1'b0;

    while (sector_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d nibbles sent over %0d random fields (%0d complete), %0d bytes checked",
             nib_cnt, fields, full_fields, bytes_cnt);
    $display("checksum beats: %0d good, %0d bad", sums_good, sums_bad);
    if (err_cnt == 0) begin
      $display("gcr_6and2_sector_decoder: match");
    end else begin
      $display("gcr_6and2_sector_decoder: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/gcr62_pkg.sv
rtl/core/gcr62_ram.sv
rtl/core/gcr62_front.sv
rtl/core/gcr_6and2_sector_decoder.sv
test/tb_top.sv
